// ===== rtl/fk6_pkg.sv =====
`default_nettype none
package fk6_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int FRAC_BITS    = 16;
   localparam int TRIG_FRAC    = 30;
   localparam int CORDIC_STEPS = 30;
   localparam int IN_W         = 16;
   localparam int OUT_W        = 24;
   localparam int BAM_W        = 32;
   localparam int TRIG_W       = 34;
   localparam int ACC_W        = 40;
   localparam int PROD_W       = 2 * TRIG_W;
   localparam int LANES        = 6;
   localparam int OUT_SHIFT    = TRIG_FRAC - FRAC_BITS;

   // Lane numbers of the six sine/cosine units.
   localparam int LANE_1  = 0;
   localparam int LANE_2  = 1;
   localparam int LANE_23 = 2;
   localparam int LANE_4  = 3;
   localparam int LANE_5  = 4;
   localparam int LANE_6  = 5;

   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic [1:0]               quad_type;
   typedef logic [BAM_W-1:0]         bam_type;

   localparam quad_type QUAD_0 = 2'd0;
   localparam quad_type QUAD_1 = 2'd1;
   localparam quad_type QUAD_2 = 2'd2;

   localparam trig_type CORDIC_GAIN = 34'sd652032874;
   localparam acc_type  ONE_Q       = acc_type'(64'sd1 <<< TRIG_FRAC);
   localparam acc_type  OUT_MAX     = acc_type'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
   localparam acc_type  OUT_MIN     = acc_type'(-(64'sd1 <<< (OUT_W - 1)));
   localparam acc_type  OUT_HALF    = acc_type'(64'sd1 <<< (OUT_SHIFT - 1));

   function automatic trig_type atan_step(input int unsigned i);
      trig_type r;
      case (i)
         0:  r = 34'sd536870912;
         1:  r = 34'sd316933406;
         2:  r = 34'sd167458907;
         3:  r = 34'sd85004756;
         4:  r = 34'sd42667331;
         5:  r = 34'sd21354465;
         6:  r = 34'sd10679838;
         7:  r = 34'sd5340245;
         8:  r = 34'sd2670163;
         9:  r = 34'sd1335087;
         10: r = 34'sd667544;
         11: r = 34'sd333772;
         12: r = 34'sd166886;
         13: r = 34'sd83443;
         14: r = 34'sd41722;
         15: r = 34'sd20861;
         16: r = 34'sd10430;
         17: r = 34'sd5215;
         18: r = 34'sd2608;
         19: r = 34'sd1304;
         20: r = 34'sd652;
         21: r = 34'sd326;
         22: r = 34'sd163;
         23: r = 34'sd81;
         24: r = 34'sd41;
         25: r = 34'sd20;
         26: r = 34'sd10;
         27: r = 34'sd5;
         28: r = 34'sd3;
         29: r = 34'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic bam_type widen(input logic [IN_W-1:0] v);
      return {v[ANGLE_BITS-1:0], {(BAM_W - ANGLE_BITS){1'b0}}};
   endfunction

   function automatic quad_type quadrant(input bam_type a);
      bam_type t;
      t = a + bam_type'(32'h2000_0000);
      return t[BAM_W-1:BAM_W-2];
   endfunction

   // Residual angle after removing the quadrant, as a signed turn fraction.
   function automatic trig_type residual(input bam_type a);
      bam_type d;
      d = a - {quadrant(a), {(BAM_W - 2){1'b0}}};
      return trig_type'(signed'(d));
   endfunction

   // Q30 by Q30 product, rounded half up.
   function automatic trig_type qmul(input trig_type a, input trig_type b);
      logic signed [PROD_W-1:0] p;
      p = a * b;
      p = p + (PROD_W'(1) <<< (TRIG_FRAC - 1));
      return p[TRIG_FRAC + TRIG_W - 1:TRIG_FRAC];
   endfunction

   function automatic acc_type ext(input trig_type a);
      return acc_type'(a);
   endfunction

   function automatic logic [OUT_W-1:0] to_out(input acc_type v);
      acc_type r;
      r = (v + OUT_HALF) >>> OUT_SHIFT;
      if (r > OUT_MAX) r = OUT_MAX;
      if (r < OUT_MIN) r = OUT_MIN;
      return r[OUT_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/forward_kinematics_six_joint.sv =====
`default_nettype none
// Forward kinematics of a fixed six-joint arm: six binary joint angles in, the end-effector
// position (x, y, z) out as signed Q8.16 words, saturated at the 24-bit limits. The block is a
// 38-stage pipeline (angle load, 30 CORDIC steps per sine/cosine unit, a quadrant fix-up, five
// multiply and sum stages, and the output register); it takes one word every cycle when not
// stalled. A stall on the result side while the output word is full freezes the whole pipeline
// and is passed straight back as req_stall.
module forward_kinematics_six_joint (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire  [fk6_pkg::IN_W-1:0]        req_angle_one,
   input  wire  [fk6_pkg::IN_W-1:0]        req_angle_two,
   input  wire  [fk6_pkg::IN_W-1:0]        req_angle_three,
   input  wire  [fk6_pkg::IN_W-1:0]        req_angle_four,
   input  wire  [fk6_pkg::IN_W-1:0]        req_angle_five,
   input  wire  [fk6_pkg::IN_W-1:0]        req_angle_six,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic signed [fk6_pkg::OUT_W-1:0] rsp_pos_x,
   output logic signed [fk6_pkg::OUT_W-1:0] rsp_pos_y,
   output logic signed [fk6_pkg::OUT_W-1:0] rsp_pos_z
);

   localparam int NL = fk6_pkg::LANES;
   localparam int CS = fk6_pkg::CORDIC_STEPS;

   logic adv;
   fk6_pkg::bam_type bam_in [NL];

   // CORDIC pipeline; index k holds the word after k steps.
   fk6_pkg::trig_type  cx_ff [NL][CS+1];
   fk6_pkg::trig_type  cy_ff [NL][CS+1];
   fk6_pkg::trig_type  cz_ff [NL][CS+1];
   fk6_pkg::quad_type  cq_ff [NL][CS+1];
   logic               cv_ff [CS+1];

   fk6_pkg::trig_type  c_ff [NL];
   fk6_pkg::trig_type  s_ff [NL];
   logic               tv_ff;

   // First product stage.
   fk6_pkg::trig_type  a_ff, b_ff, p_ff, q_ff, c1c2_ff, s1c2_ff, c4s1_ff, s1s4_ff;
   fk6_pkg::trig_type  c1c4_ff, c1s4_ff, s5c23_ff, c4c5_ff, s4s6_ff;
   fk6_pkg::trig_type  m1_c_ff [NL];
   fk6_pkg::trig_type  m1_s_ff [NL];
   logic               m1v_ff;

   // Second product stage.
   fk6_pkg::trig_type  s4a_ff, c4a_ff, s4b_ff, c4b_ff, s5p_ff, s5q_ff, w46_ff, c45s23_ff;
   fk6_pkg::trig_type  m2_c4s1_ff, m2_s1s4_ff, m2_c1c4_ff, m2_c1s4_ff, m2_s5c23_ff;
   fk6_pkg::trig_type  m2_c5_ff, m2_s6_ff, m2_c6_ff;
   fk6_pkg::acc_type   bx_ff, by_ff, bz_ff;
   logic               m2v_ff;

   // Third product stage.
   fk6_pkg::trig_type  ux1_ff, ux2_ff, uy1_ff, uy2_ff, wz_ff;
   fk6_pkg::trig_type  m3_s5p_ff, m3_s5q_ff, m3_w46_ff, m3_c6_ff;
   fk6_pkg::acc_type   m3_bx_ff, m3_by_ff, m3_bz_ff;
   logic               m3v_ff;

   // Fourth product stage.
   fk6_pkg::trig_type  vx_ff, vy_ff, vz_ff, m4_ux1_ff, m4_uy1_ff, m4_w46_ff;
   fk6_pkg::acc_type   m4_bx_ff, m4_by_ff, m4_bz_ff;
   logic               m4v_ff;

   fk6_pkg::acc_type   sx_ff, sy_ff, sz_ff;
   logic               m5v_ff;

   logic rsp_valid_ff;
   logic [fk6_pkg::OUT_W-1:0] rsp_pos_x_ff, rsp_pos_y_ff, rsp_pos_z_ff;

   // The pipeline moves whenever the output word is empty or being taken.
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_comb begin
      bam_in[fk6_pkg::LANE_1]  = fk6_pkg::widen(req_angle_one);
      bam_in[fk6_pkg::LANE_2]  = fk6_pkg::widen(req_angle_two);
      bam_in[fk6_pkg::LANE_23] = fk6_pkg::widen(req_angle_two) + fk6_pkg::widen(req_angle_three);
      bam_in[fk6_pkg::LANE_4]  = fk6_pkg::widen(req_angle_four);
      bam_in[fk6_pkg::LANE_5]  = fk6_pkg::widen(req_angle_five);
      bam_in[fk6_pkg::LANE_6]  = fk6_pkg::widen(req_angle_six);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CS; k++) begin
            cv_ff[k] <= 1'b0;
         end
         tv_ff        <= 1'b0;
         m1v_ff       <= 1'b0;
         m2v_ff       <= 1'b0;
         m3v_ff       <= 1'b0;
         m4v_ff       <= 1'b0;
         m5v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= req_valid;
         for (int k = 0; k < CS; k++) begin
            cv_ff[k+1] <= cv_ff[k];
         end
         tv_ff        <= cv_ff[CS];
         m1v_ff       <= tv_ff;
         m2v_ff       <= m1v_ff;
         m3v_ff       <= m2v_ff;
         m4v_ff       <= m3v_ff;
         m5v_ff       <= m4v_ff;
         rsp_valid_ff <= m5v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < NL; l++) begin
            cx_ff[l][0] <= fk6_pkg::CORDIC_GAIN;
            cy_ff[l][0] <= '0;
            cz_ff[l][0] <= fk6_pkg::residual(bam_in[l]);
            cq_ff[l][0] <= fk6_pkg::quadrant(bam_in[l]);
         end
         // One rotation step per stage.
         for (int k = 0; k < CS; k++) begin
            for (int l = 0; l < NL; l++) begin
               cq_ff[l][k+1] <= cq_ff[l][k];
               if (!cz_ff[l][k][fk6_pkg::TRIG_W-1]) begin
                  cx_ff[l][k+1] <= cx_ff[l][k] - (cy_ff[l][k] >>> k);
                  cy_ff[l][k+1] <= cy_ff[l][k] + (cx_ff[l][k] >>> k);
                  cz_ff[l][k+1] <= cz_ff[l][k] - fk6_pkg::atan_step(k);
               end else begin
                  cx_ff[l][k+1] <= cx_ff[l][k] + (cy_ff[l][k] >>> k);
                  cy_ff[l][k+1] <= cy_ff[l][k] - (cx_ff[l][k] >>> k);
                  cz_ff[l][k+1] <= cz_ff[l][k] + fk6_pkg::atan_step(k);
               end
            end
         end
         for (int l = 0; l < NL; l++) begin
            case (cq_ff[l][CS])
               fk6_pkg::QUAD_0: begin
                  c_ff[l] <= cx_ff[l][CS];
                  s_ff[l] <= cy_ff[l][CS];
               end
               fk6_pkg::QUAD_1: begin
                  c_ff[l] <= -cy_ff[l][CS];
                  s_ff[l] <= cx_ff[l][CS];
               end
               fk6_pkg::QUAD_2: begin
                  c_ff[l] <= -cx_ff[l][CS];
                  s_ff[l] <= -cy_ff[l][CS];
               end
               default: begin
                  c_ff[l] <= cy_ff[l][CS];
                  s_ff[l] <= -cx_ff[l][CS];
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff     <= fk6_pkg::qmul(c_ff[fk6_pkg::LANE_1], c_ff[fk6_pkg::LANE_23]);
         b_ff     <= fk6_pkg::qmul(s_ff[fk6_pkg::LANE_1], c_ff[fk6_pkg::LANE_23]);
         p_ff     <= fk6_pkg::qmul(c_ff[fk6_pkg::LANE_1], s_ff[fk6_pkg::LANE_23]);
         q_ff     <= fk6_pkg::qmul(s_ff[fk6_pkg::LANE_1], s_ff[fk6_pkg::LANE_23]);
         c1c2_ff  <= fk6_pkg::qmul(c_ff[fk6_pkg::LANE_1], c_ff[fk6_pkg::LANE_2]);
         s1c2_ff  <= fk6_pkg::qmul(s_ff[fk6_pkg::LANE_1], c_ff[fk6_pkg::LANE_2]);
         c4s1_ff  <= fk6_pkg::qmul(c_ff[fk6_pkg::LANE_4], s_ff[fk6_pkg::LANE_1]);
         s1s4_ff  <= fk6_pkg::qmul(s_ff[fk6_pkg::LANE_1], s_ff[fk6_pkg::LANE_4]);
         c1c4_ff  <= fk6_pkg::qmul(c_ff[fk6_pkg::LANE_1], c_ff[fk6_pkg::LANE_4]);
         c1s4_ff  <= fk6_pkg::qmul(c_ff[fk6_pkg::LANE_1], s_ff[fk6_pkg::LANE_4]);
         s5c23_ff <= fk6_pkg::qmul(s_ff[fk6_pkg::LANE_5], c_ff[fk6_pkg::LANE_23]);
         c4c5_ff  <= fk6_pkg::qmul(c_ff[fk6_pkg::LANE_4], c_ff[fk6_pkg::LANE_5]);
         s4s6_ff  <= fk6_pkg::qmul(s_ff[fk6_pkg::LANE_4], s_ff[fk6_pkg::LANE_6]);
         for (int l = 0; l < NL; l++) begin
            m1_c_ff[l] <= c_ff[l];
            m1_s_ff[l] <= s_ff[l];
         end

         s4a_ff      <= fk6_pkg::qmul(m1_s_ff[fk6_pkg::LANE_4], a_ff);
         c4a_ff      <= fk6_pkg::qmul(m1_c_ff[fk6_pkg::LANE_4], a_ff);
         s4b_ff      <= fk6_pkg::qmul(m1_s_ff[fk6_pkg::LANE_4], b_ff);
         c4b_ff      <= fk6_pkg::qmul(m1_c_ff[fk6_pkg::LANE_4], b_ff);
         s5p_ff      <= fk6_pkg::qmul(m1_s_ff[fk6_pkg::LANE_5], p_ff);
         s5q_ff      <= fk6_pkg::qmul(m1_s_ff[fk6_pkg::LANE_5], q_ff);
         w46_ff      <= fk6_pkg::qmul(s4s6_ff, m1_s_ff[fk6_pkg::LANE_23]);
         c45s23_ff   <= fk6_pkg::qmul(c4c5_ff, m1_s_ff[fk6_pkg::LANE_23]);
         m2_c4s1_ff  <= c4s1_ff;
         m2_s1s4_ff  <= s1s4_ff;
         m2_c1c4_ff  <= c1c4_ff;
         m2_c1s4_ff  <= c1s4_ff;
         m2_s5c23_ff <= s5c23_ff;
         m2_c5_ff    <= m1_c_ff[fk6_pkg::LANE_5];
         m2_s6_ff    <= m1_s_ff[fk6_pkg::LANE_6];
         m2_c6_ff    <= m1_c_ff[fk6_pkg::LANE_6];
         // Terms that need no further products.
         bx_ff <= fk6_pkg::ext(m1_c_ff[fk6_pkg::LANE_1]) * 2 + fk6_pkg::ext(c1c2_ff) * 14
                + fk6_pkg::ext(a_ff) * 3 + fk6_pkg::ext(p_ff) * 15;
         by_ff <= fk6_pkg::ext(m1_s_ff[fk6_pkg::LANE_1]) * 2 + fk6_pkg::ext(s1c2_ff) * 14
                + fk6_pkg::ext(b_ff) * 3 + fk6_pkg::ext(q_ff) * 15;
         bz_ff <= fk6_pkg::ONE_Q * 10 + fk6_pkg::ext(m1_s_ff[fk6_pkg::LANE_2]) * 14
                - fk6_pkg::ext(m1_c_ff[fk6_pkg::LANE_23]) * 15
                + fk6_pkg::ext(m1_s_ff[fk6_pkg::LANE_23]) * 3;

         ux1_ff    <= fk6_pkg::qmul(m2_s6_ff, m2_c4s1_ff - s4a_ff);
         ux2_ff    <= fk6_pkg::qmul(m2_c5_ff, m2_s1s4_ff + c4a_ff);
         uy1_ff    <= fk6_pkg::qmul(m2_s6_ff, m2_c1c4_ff + s4b_ff);
         uy2_ff    <= fk6_pkg::qmul(m2_c5_ff, m2_c1s4_ff - c4b_ff);
         wz_ff     <= m2_s5c23_ff + c45s23_ff;
         m3_s5p_ff <= s5p_ff;
         m3_s5q_ff <= s5q_ff;
         m3_w46_ff <= w46_ff;
         m3_c6_ff  <= m2_c6_ff;
         m3_bx_ff  <= bx_ff;
         m3_by_ff  <= by_ff;
         m3_bz_ff  <= bz_ff;

         vx_ff     <= fk6_pkg::qmul(m3_c6_ff, ux2_ff - m3_s5p_ff);
         vy_ff     <= fk6_pkg::qmul(m3_c6_ff, uy2_ff + m3_s5q_ff);
         vz_ff     <= fk6_pkg::qmul(m3_c6_ff, wz_ff);
         m4_ux1_ff <= ux1_ff;
         m4_uy1_ff <= uy1_ff;
         m4_w46_ff <= m3_w46_ff;
         m4_bx_ff  <= m3_bx_ff;
         m4_by_ff  <= m3_by_ff;
         m4_bz_ff  <= m3_bz_ff;

         sx_ff <= m4_bx_ff - fk6_pkg::ext(m4_ux1_ff) * 3 - fk6_pkg::ext(vx_ff) * 3;
         sy_ff <= m4_by_ff + fk6_pkg::ext(m4_uy1_ff) * 3 + fk6_pkg::ext(vy_ff) * 3;
         sz_ff <= m4_bz_ff + fk6_pkg::ext(m4_w46_ff) * 3 - fk6_pkg::ext(vz_ff) * 3;

         rsp_pos_x_ff <= fk6_pkg::to_out(sx_ff);
         rsp_pos_y_ff <= fk6_pkg::to_out(sy_ff);
         rsp_pos_z_ff <= fk6_pkg::to_out(sz_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = signed'(rsp_pos_x_ff);
   assign rsp_pos_y = signed'(rsp_pos_y_ff);
   assign rsp_pos_z = signed'(rsp_pos_z_ff);

endmodule
`default_nettype wire
